### sv/hsrs_pkg.sv
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer package
// Bus control codes, controller status codes, step numbers and the CRC-8
// check used by the read sequencer.
// ----------------------------------------------------------------------------
package hsrs_pkg;

	localparam logic       OP_START = 1'b0;
	localparam logic       OP_STEP  = 1'b1;

	localparam logic [7:0] CTL_NONE      = 8'h00;
	localparam logic [7:0] CTL_START     = 8'hA4;
	localparam logic [7:0] CTL_SEND      = 8'h84;
	localparam logic [7:0] CTL_READ_ACK  = 8'hC4;
	localparam logic [7:0] CTL_READ_NACK = 8'h84;
	localparam logic [7:0] CTL_RESTART   = 8'hB4;
	localparam logic [7:0] CTL_STOP      = 8'h94;

	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK = 8'h48;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;

	localparam logic [3:0] STEP_IDLE     = 4'd0;
	localparam logic [3:0] STEP_START    = 4'd1;
	localparam logic [3:0] STEP_ADDR_W   = 4'd2;
	localparam logic [3:0] STEP_CMD_HI   = 4'd3;
	localparam logic [3:0] STEP_CMD_LO   = 4'd4;
	localparam logic [3:0] STEP_RESTART  = 4'd5;
	localparam logic [3:0] STEP_ADDR_R   = 4'd6;
	localparam logic [3:0] STEP_T_HI     = 4'd7;
	localparam logic [3:0] STEP_T_LO     = 4'd8;
	localparam logic [3:0] STEP_T_CRC    = 4'd9;
	localparam logic [3:0] STEP_H_HI     = 4'd10;
	localparam logic [3:0] STEP_H_LO     = 4'd11;
	localparam logic [3:0] STEP_H_CRC    = 4'd12;

	localparam logic       REG_DEVICE_ADDRESS  = 1'b0;
	localparam logic       REG_MEASURE_COMMAND = 1'b1;

	localparam logic [6:0]  DEVICE_ADDRESS_RST  = 7'h44;
	localparam logic [15:0] MEASURE_COMMAND_RST = 16'h2C06;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	function automatic logic [7:0] crc8_round(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_word(input logic [15:0] w);
		logic [7:0] c;
		c = crc8_round(CRC_INIT ^ w[15:8]);
		c = crc8_round(c ^ w[7:0]);
		return c;
	endfunction

endpackage

### sv/humidity_sensor_read_sequencer.sv
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer
// Steps a two-wire bus controller through one measurement read and checks
// the two CRC-8 bytes of the returned data words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): opcode 0 starts a new read, opcode 1
//   reports a completed bus step with its status byte and received byte.
//   Every input word yields exactly one output word on out_valid/out_ready:
//   the next control byte, the byte to transmit, end and error flags, the
//   CRC result and the current data words.
//   An accepted word passes the input register, then the output register;
//   one word is taken every cycle unless the receiver stalls, set by the
//   single sequencer state update in the stage feeding the output register.
//   When the receiver stalls, the output word holds and the input register
//   fills; in_ready drops only when both are occupied.
//   Configuration (cfg_valid/cfg_index/cfg_data) is always ready; index 0
//   sets the 7-bit device address, index 1 the 16-bit measurement command.
//   Reset returns the sequencer to idle, clears the data words and check
//   bytes and restores the configuration defaults.
// ----------------------------------------------------------------------------
module humidity_sensor_read_sequencer
	import hsrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  bus_status,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  bus_control,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        done_res,
	output logic [3:0]  error_code,
	output logic        crc_ok,
	output logic [15:0] temperature_raw,
	output logic [15:0] humidity_raw,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  status_s1;
	logic [7:0]  rx_s1;
	logic        advance;

	logic [6:0]  dev_addr_q;
	logic [15:0] meas_cmd_q;
	logic [3:0]  step_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic [7:0]  temp_check_q;
	logic [7:0]  hum_check_q;

	logic [3:0]  step_n;
	logic [15:0] temp_word_n;
	logic [15:0] hum_word_n;
	logic [7:0]  temp_check_n;
	logic [7:0]  hum_check_n;
	logic [7:0]  ctl_c;
	logic [7:0]  tx_c;
	logic        txv_c;
	logic        done_c;
	logic [3:0]  err_c;
	logic        ok_c;
	logic [7:0]  expect_c;
	logic [7:0]  nack_c;
	logic        has_nack_c;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			status_s1 <= bus_status;
			rx_s1     <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RST;
			meas_cmd_q <= MEASURE_COMMAND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS:  dev_addr_q <= cfg_data[6:0];
				REG_MEASURE_COMMAND: meas_cmd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		step_n       = step_q;
		temp_word_n  = temp_word_q;
		hum_word_n   = hum_word_q;
		temp_check_n = temp_check_q;
		hum_check_n  = hum_check_q;
		ctl_c        = CTL_NONE;
		tx_c         = 8'h00;
		txv_c        = 1'b0;
		done_c       = 1'b0;
		err_c        = 4'd0;
		ok_c         = 1'b0;
		expect_c     = ST_RX_ACK;
		nack_c       = 8'h00;
		has_nack_c   = 1'b0;

		case (step_q)
			STEP_START, STEP_RESTART: expect_c = ST_START;
			STEP_ADDR_W: begin
				expect_c   = ST_SLAW_ACK;
				nack_c     = ST_SLAW_NACK;
				has_nack_c = 1'b1;
			end
			STEP_CMD_HI, STEP_CMD_LO: begin
				expect_c   = ST_DATA_ACK;
				nack_c     = ST_DATA_NACK;
				has_nack_c = 1'b1;
			end
			STEP_ADDR_R: begin
				expect_c   = ST_SLAR_ACK;
				nack_c     = ST_SLAR_NACK;
				has_nack_c = 1'b1;
			end
			STEP_H_CRC: expect_c = ST_RX_NACK;
			default:    expect_c = ST_RX_ACK;
		endcase

		if (opcode_s1 == OP_START) begin
			temp_word_n  = 16'h0000;
			hum_word_n   = 16'h0000;
			temp_check_n = 8'h00;
			hum_check_n  = 8'h00;
			ctl_c        = CTL_START;
			step_n       = STEP_START;
		end else if (step_q >= STEP_START && step_q <= STEP_H_CRC) begin
			if (status_s1 != expect_c) begin
				if (has_nack_c && status_s1 == nack_c) begin
					ctl_c = CTL_STOP;
				end
				err_c  = step_q;
				done_c = 1'b1;
				step_n = STEP_IDLE;
			end else begin
				step_n = (step_q == STEP_H_CRC) ? STEP_IDLE : step_q + 4'd1;
				case (step_q)
					STEP_START: begin
						ctl_c = CTL_SEND;
						tx_c  = {dev_addr_q, 1'b0};
						txv_c = 1'b1;
					end
					STEP_ADDR_W: begin
						ctl_c = CTL_SEND;
						tx_c  = meas_cmd_q[15:8];
						txv_c = 1'b1;
					end
					STEP_CMD_HI: begin
						ctl_c = CTL_SEND;
						tx_c  = meas_cmd_q[7:0];
						txv_c = 1'b1;
					end
					STEP_CMD_LO: ctl_c = CTL_RESTART;
					STEP_RESTART: begin
						ctl_c = CTL_SEND;
						tx_c  = {dev_addr_q, 1'b1};
						txv_c = 1'b1;
					end
					STEP_ADDR_R: ctl_c = CTL_READ_ACK;
					STEP_T_HI: begin
						temp_word_n = {rx_s1, 8'h00};
						ctl_c       = CTL_READ_ACK;
					end
					STEP_T_LO: begin
						temp_word_n = {temp_word_q[15:8], temp_word_q[7:0] | rx_s1};
						ctl_c       = CTL_READ_ACK;
					end
					STEP_T_CRC: begin
						temp_check_n = rx_s1;
						ctl_c        = CTL_READ_ACK;
					end
					STEP_H_HI: begin
						hum_word_n = {rx_s1, 8'h00};
						ctl_c      = CTL_READ_ACK;
					end
					STEP_H_LO: begin
						hum_word_n = {hum_word_q[15:8], hum_word_q[7:0] | rx_s1};
						ctl_c      = CTL_READ_NACK;
					end
					default: begin
						hum_check_n = rx_s1;
						ctl_c       = CTL_STOP;
						done_c      = 1'b1;
						ok_c        = (crc8_word(hum_word_q) == rx_s1) &&
						              (crc8_word(temp_word_q) == temp_check_q);
					end
				endcase
			end
		end else begin
			step_n = STEP_IDLE;
		end
	end

	// advance sequencer state with each word leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_IDLE;
			temp_word_q  <= 16'h0000;
			hum_word_q   <= 16'h0000;
			temp_check_q <= 8'h00;
			hum_check_q  <= 8'h00;
		end else if (advance) begin
			step_q       <= step_n;
			temp_word_q  <= temp_word_n;
			hum_word_q   <= hum_word_n;
			temp_check_q <= temp_check_n;
			hum_check_q  <= hum_check_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bus_control     <= ctl_c;
			tx_byte         <= tx_c;
			tx_valid        <= txv_c;
			done_res        <= done_c;
			error_code      <= err_c;
			crc_ok          <= ok_c;
			temperature_raw <= temp_word_n;
			humidity_raw    <= hum_word_n;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_H_CRC)
		else $error("sequencer step out of range");

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && done_c |=> step_q == STEP_IDLE)
		else $error("sequencer not idle after end of sequence");

	a_tx_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> bus_control == CTL_SEND && !done_res)
		else $error("transmit byte without send control");

	a_crc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crc_ok |-> done_res && error_code == 4'd0)
		else $error("crc_ok without clean completion");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 4'd0 |-> done_res && !tx_valid)
		else $error("error code without end of sequence");

endmodule

### tb/humidity_sensor_read_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Humidity sensor read sequencer testbench
// Runs a table of directed bus events through the sequencer and then
// randomized measurement reads: mostly well-formed reads with random data,
// plus bad status codes, aborted reads, stray completions and bad CRC bytes.
// Register settings change between phases, and only while nothing is pending.
// Every output word is checked field by field against an in-bench sequencer
// model or the pinned table fields. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module humidity_sensor_read_sequencer_tb;
	import hsrs_pkg::*;

	typedef struct packed {
		logic [7:0]  ctl;
		logic [7:0]  tx;
		logic        txv;
		logic        done;
		logic [3:0]  err;
		logic        ok;
		logic [15:0] temp;
		logic [15:0] hum;
	} seq_word_t;

	typedef struct {
		logic       op;
		logic [7:0] st;
		logic [7:0] rx;
		bit         pinned;
		logic [7:0] ctl;
		logic [7:0] tx;
		logic       txv;
		logic       done;
		logic [3:0] err;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = OP_STEP;
	logic [7:0]  bus_status = 8'h00;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  bus_control;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic        done_res;
	logic [3:0]  error_code;
	logic        crc_ok;
	logic [15:0] temperature_raw;
	logic [15:0] humidity_raw;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_DEVICE_ADDRESS;
	logic [15:0] cfg_data = 16'h0000;

	// sequencer model state
	logic [3:0]  seq_step = STEP_IDLE;
	logic [15:0] temp_word = 16'h0000;
	logic [15:0] hum_word = 16'h0000;
	logic [7:0]  temp_crc_byte = 8'h00;
	logic [7:0]  hum_crc_byte = 8'h00;
	logic [6:0]  dev_addr = DEVICE_ADDRESS_RST;
	logic [15:0] meas_cmd = MEASURE_COMMAND_RST;

	seq_word_t   awaited_words[$];
	bit          pin_on = 1'b0;
	seq_word_t   pin_word = '0;
	bit          steady = 1'b0;
	int          mismatches = 0;
	int          sent_items = 0;
	int          quiet = 0;

	plan_row_t plan [23] = '{
		'{OP_STEP,  8'hFF,        8'hFF, 1'b1, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_START, 8'h00,        8'h00, 1'b1, CTL_START,    8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_START,     8'h00, 1'b1, CTL_SEND,     8'h88, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_SLAW_ACK,  8'h00, 1'b1, CTL_SEND,     8'h2C, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_DATA_ACK,  8'h00, 1'b1, CTL_SEND,     8'h06, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_DATA_ACK,  8'h00, 1'b1, CTL_RESTART,  8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_START,     8'h00, 1'b1, CTL_SEND,     8'h89, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_SLAR_ACK,  8'h00, 1'b1, CTL_READ_ACK, 8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_ACK,    8'hBE, 1'b0, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_ACK,    8'hEF, 1'b0, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_ACK,    8'h92, 1'b0, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_ACK,    8'hBE, 1'b0, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_ACK,    8'hEF, 1'b0, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_RX_NACK,   8'h92, 1'b1, CTL_STOP,     8'h00, 1'b0, 1'b1, 4'd0},
		'{OP_START, 8'h00,        8'h00, 1'b1, CTL_START,    8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_START,     8'h00, 1'b1, CTL_SEND,     8'h88, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_SLAW_ACK,  8'h00, 1'b1, CTL_SEND,     8'h2C, 1'b1, 1'b0, 4'd0},
		'{OP_START, 8'hFF,        8'hFF, 1'b1, CTL_START,    8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  ST_START,     8'h00, 1'b1, CTL_SEND,     8'h88, 1'b1, 1'b0, 4'd0},
		'{OP_STEP,  ST_SLAW_NACK, 8'h00, 1'b1, CTL_STOP,     8'h00, 1'b0, 1'b1, 4'd2},
		'{OP_STEP,  8'h00,        8'h00, 1'b1, CTL_NONE,     8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_START, 8'h00,        8'h00, 1'b1, CTL_START,    8'h00, 1'b0, 1'b0, 4'd0},
		'{OP_STEP,  8'hFF,        8'h00, 1'b1, CTL_NONE,     8'h00, 1'b0, 1'b1, 4'd1}
	};

	humidity_sensor_read_sequencer u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.bus_status      (bus_status),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bus_control     (bus_control),
		.tx_byte         (tx_byte),
		.tx_valid        (tx_valid),
		.done_res        (done_res),
		.error_code      (error_code),
		.crc_ok          (crc_ok),
		.temperature_raw (temperature_raw),
		.humidity_raw    (humidity_raw),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] crc8_of(input logic [15:0] w);
		logic [7:0] c;
		c = 8'hFF;
		for (int i = 15; i >= 0; i--) begin
			if (c[7] ^ w[i])
				c = {c[6:0], 1'b0} ^ 8'h31;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] ack_status(input logic [3:0] s);
		case (s)
			STEP_START, STEP_RESTART: return ST_START;
			STEP_ADDR_W:              return ST_SLAW_ACK;
			STEP_CMD_HI, STEP_CMD_LO: return ST_DATA_ACK;
			STEP_ADDR_R:              return ST_SLAR_ACK;
			STEP_H_CRC:               return ST_RX_NACK;
			default:                  return ST_RX_ACK;
		endcase
	endfunction

	function automatic bit step_has_nack(input logic [3:0] s);
		return s inside {STEP_ADDR_W, STEP_CMD_HI, STEP_CMD_LO, STEP_ADDR_R};
	endfunction

	function automatic logic [7:0] nack_status(input logic [3:0] s);
		case (s)
			STEP_ADDR_W:              return ST_SLAW_NACK;
			STEP_CMD_HI, STEP_CMD_LO: return ST_DATA_NACK;
			default:                  return ST_SLAR_NACK;
		endcase
	endfunction

	function automatic seq_word_t advance_sequencer(input logic op, input logic [7:0] st,
			input logic [7:0] rx);
		seq_word_t r;
		logic [3:0] s;
		r = '0;
		s = seq_step;
		if (op == OP_START) begin
			temp_word = 16'h0000;
			hum_word = 16'h0000;
			temp_crc_byte = 8'h00;
			hum_crc_byte = 8'h00;
			r.ctl = CTL_START;
			seq_step = STEP_START;
		end else if (s >= STEP_START && s <= STEP_H_CRC) begin
			if (st != ack_status(s)) begin
				if (step_has_nack(s) && st == nack_status(s))
					r.ctl = CTL_STOP;
				r.err = s;
				r.done = 1'b1;
				seq_step = STEP_IDLE;
			end else begin
				case (s)
					STEP_START: begin
						r.ctl = CTL_SEND;
						r.tx = {dev_addr, 1'b0};
						r.txv = 1'b1;
					end
					STEP_ADDR_W: begin
						r.ctl = CTL_SEND;
						r.tx = meas_cmd[15:8];
						r.txv = 1'b1;
					end
					STEP_CMD_HI: begin
						r.ctl = CTL_SEND;
						r.tx = meas_cmd[7:0];
						r.txv = 1'b1;
					end
					STEP_CMD_LO: r.ctl = CTL_RESTART;
					STEP_RESTART: begin
						r.ctl = CTL_SEND;
						r.tx = {dev_addr, 1'b1};
						r.txv = 1'b1;
					end
					STEP_ADDR_R: r.ctl = CTL_READ_ACK;
					STEP_T_HI: begin
						temp_word = {rx, 8'h00};
						r.ctl = CTL_READ_ACK;
					end
					STEP_T_LO: begin
						temp_word = temp_word | {8'h00, rx};
						r.ctl = CTL_READ_ACK;
					end
					STEP_T_CRC: begin
						temp_crc_byte = rx;
						r.ctl = CTL_READ_ACK;
					end
					STEP_H_HI: begin
						hum_word = {rx, 8'h00};
						r.ctl = CTL_READ_ACK;
					end
					STEP_H_LO: begin
						hum_word = hum_word | {8'h00, rx};
						r.ctl = CTL_READ_NACK;
					end
					default: begin
						hum_crc_byte = rx;
						r.ctl = CTL_STOP;
						r.done = 1'b1;
						r.ok = (crc8_of(hum_word) == hum_crc_byte) &&
							(crc8_of(temp_word) == temp_crc_byte);
					end
				endcase
				seq_step = (s == STEP_H_CRC) ? STEP_IDLE : s + 4'd1;
			end
		end else begin
			seq_step = STEP_IDLE;
		end
		r.temp = temp_word;
		r.hum = hum_word;
		return r;
	endfunction

	function automatic void check_word(input seq_word_t e);
		if (bus_control !== e.ctl) begin
			$error("bus_control: expected %h, got %h", e.ctl, bus_control);
			mismatches++;
		end
		if (tx_byte !== e.tx) begin
			$error("tx_byte: expected %h, got %h", e.tx, tx_byte);
			mismatches++;
		end
		if (tx_valid !== e.txv) begin
			$error("tx_valid: expected %b, got %b", e.txv, tx_valid);
			mismatches++;
		end
		if (done_res !== e.done) begin
			$error("done_res: expected %b, got %b", e.done, done_res);
			mismatches++;
		end
		if (error_code !== e.err) begin
			$error("error_code: expected %0d, got %0d", e.err, error_code);
			mismatches++;
		end
		if (crc_ok !== e.ok) begin
			$error("crc_ok: expected %b, got %b", e.ok, crc_ok);
			mismatches++;
		end
		if (temperature_raw !== e.temp) begin
			$error("temperature_raw: expected %h, got %h", e.temp, temperature_raw);
			mismatches++;
		end
		if (humidity_raw !== e.hum) begin
			$error("humidity_raw: expected %h, got %h", e.hum, humidity_raw);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : port_watch
		seq_word_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DEVICE_ADDRESS)
					dev_addr = cfg_data[6:0];
				else
					meas_cmd = cfg_data;
			end
			if (in_valid && in_ready) begin
				w = advance_sequencer(opcode, bus_status, rx_byte);
				if (pin_on) begin
					w.ctl = pin_word.ctl;
					w.tx = pin_word.tx;
					w.txv = pin_word.txv;
					w.done = pin_word.done;
					w.err = pin_word.err;
				end
				awaited_words.push_back(w);
			end
			if (out_valid && out_ready) begin
				if (awaited_words.size() == 0) begin
					$error("output word with nothing expected");
					mismatches++;
				end else begin
					check_word(awaited_words.pop_front());
				end
			end
		end
	end

	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 19);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic offer_word(input logic op, input logic [7:0] st, input logic [7:0] rx,
			input bit pinned = 1'b0, input seq_word_t fixed = '0);
		while (!steady && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		bus_status <= st;
		rx_byte <= rx;
		pin_on <= pinned;
		pin_word <= fixed;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_registers(input logic [15:0] addr_data, input logic [15:0] cmd_data);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data <= addr_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MEASURE_COMMAND;
		cfg_data <= cmd_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_read();
		logic [3:0]  s;
		logic [7:0]  st;
		logic [7:0]  rx;
		logic [15:0] t;
		logic [15:0] h;
		int          roll;
		t = 16'($urandom);
		h = 16'($urandom);
		offer_word(OP_START, 8'($urandom), 8'($urandom));
		sent_items++;
		for (int k = 1; k <= 12; k++) begin
			s = 4'(k);
			roll = $urandom_range(999);
			// drop the read here; the next start lands on a busy sequencer
			if (roll < 8)
				return;
			if (roll < 38)
				st = (step_has_nack(s) && $urandom_range(1)) ? nack_status(s) : 8'($urandom);
			else
				st = ack_status(s);
			case (s)
				STEP_T_HI:  rx = t[15:8];
				STEP_T_LO:  rx = t[7:0];
				STEP_T_CRC: rx = ($urandom_range(3) == 0) ? 8'($urandom) : crc8_of(t);
				STEP_H_HI:  rx = h[15:8];
				STEP_H_LO:  rx = h[7:0];
				STEP_H_CRC: rx = ($urandom_range(3) == 0) ? 8'($urandom) : crc8_of(h);
				default:    rx = 8'($urandom);
			endcase
			offer_word(OP_STEP, st, rx);
			sent_items++;
			if (st != ack_status(s))
				return;
		end
	endtask

	initial begin : stimulus
		seq_word_t fix;
		int        target;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			fix = '0;
			fix.ctl = plan[i].ctl;
			fix.tx = plan[i].tx;
			fix.txv = plan[i].txv;
			fix.done = plan[i].done;
			fix.err = plan[i].err;
			offer_word(plan[i].op, plan[i].st, plan[i].rx, plan[i].pinned, fix);
			sent_items++;
		end

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: load_registers(16'hFF80, 16'h0000);
				1: load_registers(16'h007F, 16'hFFFF);
				2: load_registers({9'h000, DEVICE_ADDRESS_RST}, MEASURE_COMMAND_RST);
				default: load_registers(16'($urandom), 16'($urandom));
			endcase
			steady = (ph == 2);
			target = sent_items + 400;
			while (sent_items < target) begin
				if ($urandom_range(9) == 0)
					offer_word(OP_STEP, 8'($urandom), 8'($urandom));
				random_read();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
sv/hsrs_pkg.sv
sv/humidity_sensor_read_sequencer.sv
tb/humidity_sensor_read_sequencer_tb.sv
